### rtl/tnpp_pkg.sv
// Shared types and constants for the trie node prefix parser.
// No dependencies; used by every module of the block.
package tnpp_pkg;

    localparam int LEN_BITS_DEF = 16;
    localparam int RQ_DEPTH     = 4;
    localparam int RQ_AW        = $clog2(RQ_DEPTH);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENEXT,
        PH_KEY,
        PH_MAPLO,
        PH_MAPHI,
        PH_SKIP
    } t_phase;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_KEY    = 2'd1;
    localparam logic [1:0] KIND_MAP    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] ERR_TOO_SMALL    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN_TYPE = 2'd1;
    localparam logic [1:0] ERR_TOO_MANY     = 2'd2;

    localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
    localparam logic [1:0] TYPE_LEAF    = 2'd1;

    localparam logic [1:0] CNT_ONE = 2'd1;
    localparam logic [1:0] CNT_TWO = 2'd2;

    localparam logic [5:0] HDR_LEN_EXT = 6'h3F;
    localparam logic [7:0] BYTE_CONT   = 8'hFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  node_type;
        logic [15:0] key_length;
        logic [3:0]  nibble_first;
        logic [3:0]  nibble_second;
        logic [1:0]  nibble_count;
        logic [15:0] children_map;
        logic [1:0]  error_code;
        logic        prefix_done;
        logic        last_of_run;
    } t_result;

    function automatic t_result mk_result(logic [1:0] kind, logic [1:0] node_type);
        t_result r;
        r           = '0;
        r.kind      = kind;
        r.node_type = node_type;
        return r;
    endfunction

endpackage

### rtl/tnpp_step.sv
// Per-word decode: next parser state and up to two result words.
// Depends on tnpp_pkg.
module tnpp_step import tnpp_pkg::*; #(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  t_phase              i_phase,
    input  logic [1:0]          i_held_type,
    input  logic [LEN_BITS-1:0] i_length_sum,
    input  logic                i_len_over,
    input  logic [LEN_BITS-1:0] i_key_left,
    input  logic                i_odd_pending,
    input  logic [7:0]          i_map_low,
    input  logic [7:0]          i_byte_value,
    input  logic                i_end_of_buffer,
    output t_phase              o_phase,
    output logic [1:0]          o_held_type,
    output logic [LEN_BITS-1:0] o_length_sum,
    output logic                o_len_over,
    output logic [LEN_BITS-1:0] o_key_left,
    output logic                o_odd_pending,
    output logic [7:0]          o_map_low,
    output t_result             o_res0,
    output t_result             o_res1,
    output logic [1:0]          o_count
);

    t_result               res [2];
    logic [1:0]            n;
    logic [LEN_BITS:0]     sum;
    logic [LEN_BITS+15:0]  len_ext;
    logic [LEN_BITS-1:0]   half;
    logic                  fin;
    logic                  ak;

    always_comb begin
        o_phase       = i_phase;
        o_held_type   = i_held_type;
        o_length_sum  = i_length_sum;
        o_len_over    = i_len_over;
        o_key_left    = i_key_left;
        o_odd_pending = i_odd_pending;
        o_map_low     = i_map_low;
        res[0]        = '0;
        res[1]        = '0;
        n             = 2'd0;
        fin           = 1'b0;
        ak            = 1'b0;
        sum           = {1'b0, i_length_sum} + (LEN_BITS+1)'(i_byte_value);

        unique case (i_phase)
            PH_HEADER: begin
                o_held_type  = i_byte_value[7:6];
                o_length_sum = LEN_BITS'(i_byte_value[5:0]);
                o_len_over   = 1'b0;
                if (i_byte_value[5:0] == HDR_LEN_EXT) begin
                    o_phase = PH_LENEXT;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_LENEXT: begin
                if (sum[LEN_BITS]) begin
                    o_length_sum = '1;
                    o_len_over   = 1'b1;
                end else begin
                    o_length_sum = sum[LEN_BITS-1:0];
                end
                if (i_byte_value != BYTE_CONT) begin
                    fin = 1'b1;
                end
            end
            PH_KEY: begin
                res[0] = mk_result(KIND_KEY, i_held_type);
                if (i_odd_pending) begin
                    res[0].nibble_first = i_byte_value[3:0];
                    res[0].nibble_count = CNT_ONE;
                end else begin
                    res[0].nibble_first  = i_byte_value[7:4];
                    res[0].nibble_second = i_byte_value[3:0];
                    res[0].nibble_count  = CNT_TWO;
                end
                n             = 2'd1;
                o_odd_pending = 1'b0;
                if (i_key_left != '0) begin
                    o_key_left = i_key_left - LEN_BITS'(1);
                end
                ak = (i_key_left <= LEN_BITS'(1));
            end
            PH_MAPLO: begin
                o_map_low = i_byte_value;
                o_phase   = PH_MAPHI;
            end
            PH_MAPHI: begin
                res[0]              = mk_result(KIND_MAP, i_held_type);
                res[0].children_map = {i_byte_value, i_map_low};
                res[0].prefix_done  = 1'b1;
                n                   = 2'd1;
                o_phase             = PH_SKIP;
            end
            default: begin
                o_phase = PH_SKIP;
            end
        endcase

        len_ext = {16'd0, o_length_sum};
        half    = (o_length_sum >> 1) + LEN_BITS'(o_length_sum[0]);

        if (fin) begin
            res[n[0]]            = mk_result(KIND_HEADER, o_held_type);
            res[n[0]].key_length = len_ext[15:0];
            n                    = n + 2'd1;
            if (o_len_over) begin
                res[n[0]]            = mk_result(KIND_ERROR, o_held_type);
                res[n[0]].error_code = ERR_TOO_MANY;
                n                    = n + 2'd1;
                o_phase              = PH_SKIP;
            end else begin
                o_key_left    = half;
                o_odd_pending = o_length_sum[0];
                o_phase       = PH_KEY;
                ak            = (half == '0);
            end
        end

        if (ak) begin
            if (o_held_type == TYPE_LEAF) begin
                if (n != 2'd0) begin
                    res[n[0] - 1'b1].prefix_done = 1'b1;
                end
                o_phase = PH_SKIP;
            end else if (o_held_type == TYPE_UNKNOWN) begin
                if (n < 2'd2) begin
                    res[n[0]]            = mk_result(KIND_ERROR, o_held_type);
                    res[n[0]].error_code = ERR_UNKNOWN_TYPE;
                    n                    = n + 2'd1;
                end
                o_phase = PH_SKIP;
            end else begin
                o_phase = PH_MAPLO;
            end
        end

        if (i_end_of_buffer) begin
            if (o_phase != PH_SKIP && n < 2'd2) begin
                res[n[0]]            = mk_result(KIND_ERROR, o_held_type);
                res[n[0]].error_code = ERR_TOO_SMALL;
                n                    = n + 2'd1;
            end
            o_phase       = PH_HEADER;
            o_held_type   = '0;
            o_length_sum  = '0;
            o_len_over    = 1'b0;
            o_key_left    = '0;
            o_odd_pending = 1'b0;
            o_map_low     = '0;
        end

        if (n != 2'd0) begin
            res[n[0] - 1'b1].last_of_run = 1'b1;
        end
    end

    assign o_res0  = res[0];
    assign o_res1  = res[1];
    assign o_count = n;

endmodule

### rtl/tnpp_rq.sv
// Result queue: takes up to two result words per cycle, hands out one.
// Depends on tnpp_pkg.
module tnpp_rq import tnpp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_wr0,
    input  t_result    i_wr1,
    output logic       o_space2,
    output logic       o_valid,
    output t_result    o_data,
    input  logic       i_pop
);

    t_result            r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0]   r_wp;
    logic [RQ_AW-1:0]   r_rp;
    logic [RQ_AW:0]     r_count;
    logic               pop;

    assign pop      = i_pop && (r_count != '0);
    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rp];
    assign o_space2 = (r_count <= (RQ_AW+1)'(RQ_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_wr0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wp + RQ_AW'(1)] <= i_wr1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + RQ_AW'(i_push_cnt);
            r_rp    <= r_rp + RQ_AW'(pop);
            r_count <= r_count + (RQ_AW+1)'(i_push_cnt) - (RQ_AW+1)'(pop);
        end
    end

endmodule

### rtl/trie_node_prefix_parser_core.sv
// Trie node prefix parser, top level: input register, decode, result queue.
// Depends on tnpp_pkg, tnpp_step and tnpp_rq.
//
// Takes one byte word per cycle while o_ready is high and decodes the fixed
// prefix of an encoded trie node: header, partial key as nibble pairs, and
// for branch types the 16-bit children bitmap; later bytes up to the end
// mark are dropped. A byte is held in an input register and decoded from
// there into a four-word result queue when it has room for two words. Bytes
// that yield no or one result sustain one word per cycle while the receiver
// does not stall; a byte that yields two results (header plus error, key plus
// error) takes the single output port twice, which then limits input rate.
module trie_node_prefix_parser_core import tnpp_pkg::*; #(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_end_of_buffer,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_node_type,
    output logic [15:0] o_key_length,
    output logic [3:0]  o_nibble_first,
    output logic [3:0]  o_nibble_second,
    output logic [1:0]  o_nibble_count,
    output logic [15:0] o_children_map,
    output logic [1:0]  o_error_code,
    output logic        o_prefix_done,
    output logic        o_last_of_run
);

    logic                r_in_valid;
    logic [7:0]          r_byte;
    logic                r_end;
    t_phase              r_phase;
    logic [1:0]          r_held_type;
    logic [LEN_BITS-1:0] r_length_sum;
    logic                r_len_over;
    logic [LEN_BITS-1:0] r_key_left;
    logic                r_odd_pending;
    logic [7:0]          r_map_low;

    t_phase              n_phase;
    logic [1:0]          n_held_type;
    logic [LEN_BITS-1:0] n_length_sum;
    logic                n_len_over;
    logic [LEN_BITS-1:0] n_key_left;
    logic                n_odd_pending;
    logic [7:0]          n_map_low;

    t_result             res0;
    t_result             res1;
    t_result             head;
    logic [1:0]          res_cnt;
    logic                space2;
    logic                fire;

    assign fire    = r_in_valid && space2;
    assign o_ready = !r_in_valid || space2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte_value;
            r_end  <= i_end_of_buffer;
        end
    end

    tnpp_step #(
        .LEN_BITS(LEN_BITS)
    ) u_step (
        .i_phase        (r_phase),
        .i_held_type    (r_held_type),
        .i_length_sum   (r_length_sum),
        .i_len_over     (r_len_over),
        .i_key_left     (r_key_left),
        .i_odd_pending  (r_odd_pending),
        .i_map_low      (r_map_low),
        .i_byte_value   (r_byte),
        .i_end_of_buffer(r_end),
        .o_phase        (n_phase),
        .o_held_type    (n_held_type),
        .o_length_sum   (n_length_sum),
        .o_len_over     (n_len_over),
        .o_key_left     (n_key_left),
        .o_odd_pending  (n_odd_pending),
        .o_map_low      (n_map_low),
        .o_res0         (res0),
        .o_res1         (res1),
        .o_count        (res_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_held_type   <= '0;
            r_length_sum  <= '0;
            r_len_over    <= 1'b0;
            r_key_left    <= '0;
            r_odd_pending <= 1'b0;
            r_map_low     <= '0;
        end else if (fire) begin
            r_phase       <= n_phase;
            r_held_type   <= n_held_type;
            r_length_sum  <= n_length_sum;
            r_len_over    <= n_len_over;
            r_key_left    <= n_key_left;
            r_odd_pending <= n_odd_pending;
            r_map_low     <= n_map_low;
        end
    end

    tnpp_rq u_rq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_cnt(fire ? res_cnt : 2'd0),
        .i_wr0     (res0),
        .i_wr1     (res1),
        .o_space2  (space2),
        .o_valid   (o_valid),
        .o_data    (head),
        .i_pop     (i_ready)
    );

    assign o_kind          = head.kind;
    assign o_node_type     = head.node_type;
    assign o_key_length    = head.key_length;
    assign o_nibble_first  = head.nibble_first;
    assign o_nibble_second = head.nibble_second;
    assign o_nibble_count  = head.nibble_count;
    assign o_children_map  = head.children_map;
    assign o_error_code    = head.error_code;
    assign o_prefix_done   = head.prefix_done;
    assign o_last_of_run   = head.last_of_run;

endmodule

### rtl/tnpp_checker.sv
// Port-level checks for the trie node prefix parser, bound to the top level.
// Depends on tnpp_pkg and trie_node_prefix_parser_core.
module tnpp_checker import tnpp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_kind,
    input logic [15:0] o_key_length,
    input logic [1:0]  o_nibble_count,
    input logic        o_prefix_done,
    input logic        o_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_key_length))
        else $error("result word dropped or changed while stalled");

    a_key_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_KEY |-> o_nibble_count == CNT_ONE || o_nibble_count == CNT_TWO)
        else $error("key word without one or two nibbles");

    a_err_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ERROR |-> !o_prefix_done && o_last_of_run)
        else $error("error word marked done or not last");

    a_map_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_MAP |-> o_prefix_done && o_last_of_run)
        else $error("bitmap word does not close the prefix");

endmodule

bind trie_node_prefix_parser_core tnpp_checker u_tnpp_checker (.*);

### bench/trie_node_prefix_parser_core_test.sv
// Self-checking bench for trie_node_prefix_parser_core: directed byte table, then random
// node buffers under several idle/stall mixes, each result word checked against a predictor
// or a fixed expected word. Depends on tnpp_pkg and the RTL of the parser core only.
module trie_node_prefix_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tnpp_pkg::*;

    localparam int         LEN_MAX         = (1 << LEN_BITS_DEF) - 1;
    localparam int         ITEMS_PER_PHASE = 190;
    localparam logic [1:0] TYPE_BRANCH     = 2'd2;
    localparam logic [1:0] TYPE_BRANCH_VAL = 2'd3;

    typedef struct packed {
        logic [7:0] value;
        logic       eob;
    } t_word;

    typedef struct packed {
        logic [7:0]  value;
        logic        eob;
        logic [15:0] reps;
        logic [1:0]  n_typed;
        t_result     typed_a;
        t_result     typed_b;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_byte_value;
    logic        i_end_of_buffer;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_kind;
    logic [1:0]  o_node_type;
    logic [15:0] o_key_length;
    logic [3:0]  o_nibble_first;
    logic [3:0]  o_nibble_second;
    logic [1:0]  o_nibble_count;
    logic [15:0] o_children_map;
    logic [1:0]  o_error_code;
    logic        o_prefix_done;
    logic        o_last_of_run;

    trie_node_prefix_parser_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_byte_value    (i_byte_value),
        .i_end_of_buffer (i_end_of_buffer),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_node_type     (o_node_type),
        .o_key_length    (o_key_length),
        .o_nibble_first  (o_nibble_first),
        .o_nibble_second (o_nibble_second),
        .o_nibble_count  (o_nibble_count),
        .o_children_map  (o_children_map),
        .o_error_code    (o_error_code),
        .o_prefix_done   (o_prefix_done),
        .o_last_of_run   (o_last_of_run)
    );

    // parser state mirror
    t_phase     ph;
    logic [1:0] held_ty;
    int         len_sum;
    bit         len_over;
    int         key_left;
    bit         odd_pend;
    logic [7:0] map_lo;

    t_result byte_results[$];
    t_result decoded_q[$];
    t_word   node_q[$];
    t_row    plan[$];

    int fail_count    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit pressure_req  = 1'b0;
    bit pressure_done = 1'b0;

    function automatic void parser_clear();
        ph       = PH_HEADER;
        held_ty  = '0;
        len_sum  = 0;
        len_over = 1'b0;
        key_left = 0;
        odd_pend = 1'b0;
        map_lo   = '0;
    endfunction

    function automatic void add_result(logic [1:0] kind, int klen, logic [3:0] nib_a,
                                       logic [3:0] nib_b, logic [1:0] cnt,
                                       logic [15:0] map, logic [1:0] err, logic done);
        t_result r;
        r               = '0;
        r.kind          = kind;
        r.node_type     = held_ty;
        r.key_length    = klen[15:0];
        r.nibble_first  = nib_a;
        r.nibble_second = nib_b;
        r.nibble_count  = cnt;
        r.children_map  = map;
        r.error_code    = err;
        r.prefix_done   = done;
        byte_results.push_back(r);
    endfunction

    function automatic void key_done();
        t_result r;
        if (held_ty == TYPE_LEAF) begin
            if (byte_results.size() > 0) begin
                r = byte_results.pop_back();
                r.prefix_done = 1'b1;
                byte_results.push_back(r);
            end
            ph = PH_SKIP;
        end else if (held_ty == TYPE_UNKNOWN) begin
            add_result(KIND_ERROR, 0, '0, '0, '0, '0, ERR_UNKNOWN_TYPE, 1'b0);
            ph = PH_SKIP;
        end else begin
            ph = PH_MAPLO;
        end
    endfunction

    function automatic void length_done();
        add_result(KIND_HEADER, len_sum, '0, '0, '0, '0, ERR_TOO_SMALL, 1'b0);
        if (len_over) begin
            add_result(KIND_ERROR, 0, '0, '0, '0, '0, ERR_TOO_MANY, 1'b0);
            ph = PH_SKIP;
        end else begin
            key_left = len_sum / 2 + len_sum % 2;
            odd_pend = (len_sum % 2) != 0;
            ph       = PH_KEY;
            if (key_left == 0) key_done();
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic eob);
        t_result r;
        byte_results.delete();
        case (ph)
            PH_HEADER: begin
                held_ty  = b[7:6];
                len_sum  = int'(b[5:0]);
                len_over = 1'b0;
                if (b[5:0] == HDR_LEN_EXT) ph = PH_LENEXT;
                else length_done();
            end
            PH_LENEXT: begin
                len_sum += int'(b);
                if (len_sum > LEN_MAX) begin
                    len_sum  = LEN_MAX;
                    len_over = 1'b1;
                end
                if (b != BYTE_CONT) length_done();
            end
            PH_KEY: begin
                if (odd_pend) begin
                    add_result(KIND_KEY, 0, b[3:0], '0, CNT_ONE, '0, ERR_TOO_SMALL, 1'b0);
                    odd_pend = 1'b0;
                end else begin
                    add_result(KIND_KEY, 0, b[7:4], b[3:0], CNT_TWO, '0, ERR_TOO_SMALL, 1'b0);
                end
                if (key_left > 0) key_left--;
                if (key_left == 0) key_done();
            end
            PH_MAPLO: begin
                map_lo = b;
                ph     = PH_MAPHI;
            end
            PH_MAPHI: begin
                add_result(KIND_MAP, 0, '0, '0, '0, {b, map_lo}, ERR_TOO_SMALL, 1'b1);
                ph = PH_SKIP;
            end
            default: ph = PH_SKIP;
        endcase
        if (eob) begin
            if (ph != PH_SKIP) add_result(KIND_ERROR, 0, '0, '0, '0, '0, ERR_TOO_SMALL, 1'b0);
            parser_clear();
        end
        if (byte_results.size() > 0) begin
            r = byte_results.pop_back();
            r.last_of_run = 1'b1;
            byte_results.push_back(r);
        end
    endfunction

    function automatic t_result fixed_res(logic [1:0] kind, logic [1:0] ty, logic [15:0] klen,
                                          logic [1:0] err, logic done, logic last);
        t_result r;
        r             = '0;
        r.kind        = kind;
        r.node_type   = ty;
        r.key_length  = klen;
        r.error_code  = err;
        r.prefix_done = done;
        r.last_of_run = last;
        return r;
    endfunction

    function automatic t_row row(logic [7:0] value, logic eob, int reps = 1, int n_typed = 0,
                                 t_result res_a = '0, t_result res_b = '0);
        t_row r;
        r.value   = value;
        r.eob     = eob;
        r.reps    = reps[15:0];
        r.n_typed = n_typed[1:0];
        r.typed_a = res_a;
        r.typed_b = res_b;
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // one random node buffer: mostly well formed, some cut short, some noise
    function automatic void make_node();
        int          flavor;
        int          mode;
        int          ty;
        int          klen;
        int          nkey;
        int          cut;
        int          fin;
        bit          full;
        t_word       w;
        node_q.delete();
        flavor = $urandom_range(99);
        if (flavor >= 85) begin
            repeat ($urandom_range(1, 8)) node_q.push_back({8'($urandom), 1'b0});
        end else begin
            ty   = $urandom_range(3);
            mode = $urandom_range(99);
            if (mode < 85) begin
                klen = $urandom_range(0, 12);
                node_q.push_back({ty[1:0], klen[5:0], 1'b0});
            end else begin
                node_q.push_back({ty[1:0], HDR_LEN_EXT, 1'b0});
                klen = 63;
                if (mode >= 97) begin
                    cut = (mode == 99) ? 257 + $urandom_range(0, 2) : $urandom_range(1, 2);
                    repeat (cut) node_q.push_back({BYTE_CONT, 1'b0});
                    klen += 255 * cut;
                    fin = $urandom_range(0, 254);
                end else begin
                    fin = $urandom_range(0, 40);
                end
                node_q.push_back({fin[7:0], 1'b0});
                klen += fin;
            end
            nkey = (klen + 1) / 2;
            full = 1'b1;
            if (nkey > 40) begin
                nkey = $urandom_range(1, 40);
                full = 1'b0;
            end
            repeat (nkey) node_q.push_back({8'($urandom), 1'b0});
            if (full) begin
                if (ty >= TYPE_BRANCH) repeat (2) node_q.push_back({8'($urandom), 1'b0});
                repeat ($urandom_range(0, 3)) node_q.push_back({8'($urandom), 1'b0});
            end
            if (flavor >= 70) begin
                cut = $urandom_range(1, node_q.size());
                while (node_q.size() > cut) void'(node_q.pop_back());
            end
        end
        w     = node_q.pop_back();
        w.eob = 1'b1;
        node_q.push_back(w);
    endfunction

    task automatic send_word(logic [7:0] b, logic eob, bit use_model);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_byte_value    <= b;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (!o_ready);
        decode_byte(b, eob);
        if (use_model) foreach (byte_results[k]) decoded_q.push_back(byte_results[k]);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("trie_node_prefix_parser_core test failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_req && !pressure_done) begin
                pressure_done = 1'b1;
                i_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_mon
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result word, kind %0d", o_kind);
                fail_count++;
            end else begin
                want = decoded_q.pop_front();
                check_field("kind", 16'(want.kind), 16'(o_kind));
                check_field("node_type", 16'(want.node_type), 16'(o_node_type));
                check_field("key_length", want.key_length, o_key_length);
                check_field("nibble_first", 16'(want.nibble_first), 16'(o_nibble_first));
                check_field("nibble_second", 16'(want.nibble_second), 16'(o_nibble_second));
                check_field("nibble_count", 16'(want.nibble_count), 16'(o_nibble_count));
                check_field("children_map", want.children_map, o_children_map);
                check_field("error_code", 16'(want.error_code), 16'(o_error_code));
                check_field("prefix_done", 16'(want.prefix_done), 16'(o_prefix_done));
                check_field("last_of_run", 16'(want.last_of_run), 16'(o_last_of_run));
            end
        end
    end

    initial begin : main
        int   idle_tab[4];
        int   stall_tab[4];
        int   sent;
        int   wait_cycles;
        t_row r;
        idle_tab  = '{0, 81, 0, 36};
        stall_tab = '{0, 0, 81, 36};
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_byte_value    <= '0;
        i_end_of_buffer <= 1'b0;
        parser_clear();

        // empty leaf, empty unknown type, early ends on header bytes
        plan.push_back(row(8'h40, 1'b1, 1, 1,
            fixed_res(KIND_HEADER, TYPE_LEAF, 16'd0, ERR_TOO_SMALL, 1'b1, 1'b1)));
        plan.push_back(row(8'h00, 1'b1, 1, 2,
            fixed_res(KIND_HEADER, TYPE_UNKNOWN, 16'd0, ERR_TOO_SMALL, 1'b0, 1'b0),
            fixed_res(KIND_ERROR, TYPE_UNKNOWN, 16'd0, ERR_UNKNOWN_TYPE, 1'b0, 1'b1)));
        plan.push_back(row(8'h85, 1'b1, 1, 2,
            fixed_res(KIND_HEADER, TYPE_BRANCH, 16'd5, ERR_TOO_SMALL, 1'b0, 1'b0),
            fixed_res(KIND_ERROR, TYPE_BRANCH, 16'd0, ERR_TOO_SMALL, 1'b0, 1'b1)));
        plan.push_back(row(8'hFF, 1'b1, 1, 1,
            fixed_res(KIND_ERROR, TYPE_BRANCH_VAL, 16'd0, ERR_TOO_SMALL, 1'b0, 1'b1)));
        // branch, odd key, bitmap
        plan.push_back(row(8'h81, 1'b0));
        plan.push_back(row(8'hAB, 1'b0));
        plan.push_back(row(8'h34, 1'b0));
        plan.push_back(row(8'h12, 1'b1));
        // branch with value, even key, trailing byte skipped
        plan.push_back(row(8'hC2, 1'b0));
        plan.push_back(row(8'hFF, 1'b0));
        plan.push_back(row(8'h00, 1'b0));
        plan.push_back(row(8'hFF, 1'b0));
        plan.push_back(row(8'h55, 1'b1));
        // leaf, odd key of three nibbles
        plan.push_back(row(8'h43, 1'b0));
        plan.push_back(row(8'h0A, 1'b0));
        plan.push_back(row(8'hBC, 1'b0));
        plan.push_back(row(8'h99, 1'b1));
        // unknown type after key
        plan.push_back(row(8'h02, 1'b0));
        plan.push_back(row(8'h12, 1'b0));
        plan.push_back(row(8'h77, 1'b1));
        // length overflow saturates
        plan.push_back(row(8'h7F, 1'b0));
        plan.push_back(row(8'hFF, 1'b0, 257));
        plan.push_back(row(8'h00, 1'b1, 1, 2,
            fixed_res(KIND_HEADER, TYPE_LEAF, 16'hFFFF, ERR_TOO_SMALL, 1'b0, 1'b0),
            fixed_res(KIND_ERROR, TYPE_LEAF, 16'd0, ERR_TOO_MANY, 1'b0, 1'b1)));
        // length exactly at the maximum, then buffer ends
        plan.push_back(row(8'h7F, 1'b0));
        plan.push_back(row(8'hFF, 1'b0, 256));
        plan.push_back(row(8'hC0, 1'b1, 1, 2,
            fixed_res(KIND_HEADER, TYPE_LEAF, 16'hFFFF, ERR_TOO_SMALL, 1'b0, 1'b0),
            fixed_res(KIND_ERROR, TYPE_LEAF, 16'd0, ERR_TOO_SMALL, 1'b0, 1'b1)));
        // extended length, cut inside the key
        plan.push_back(row(8'h3F, 1'b0));
        plan.push_back(row(8'hFE, 1'b0));
        plan.push_back(row(8'hF0, 1'b1));
        // branch with empty key, full bitmap
        plan.push_back(row(8'hC0, 1'b0));
        plan.push_back(row(8'hFF, 1'b0));
        plan.push_back(row(8'hFF, 1'b1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[idx]) begin
            r = plan[idx];
            repeat (r.reps) begin
                send_word(r.value, r.eob, r.n_typed == 0);
                if (r.n_typed != 0) begin
                    decoded_q.push_back(r.typed_a);
                    if (r.n_typed == 2) decoded_q.push_back(r.typed_b);
                end
            end
        end

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_tab[p];
            stall_pct     = stall_tab[p];
            if (p == 0) pressure_req = 1'b1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                make_node();
                foreach (node_q[k]) send_word(node_q[k].value, node_q[k].eob, 1'b1);
                sent += node_q.size();
            end
        end
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (decoded_q.size() > 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (decoded_q.size() > 0) begin
            $error("%0d expected result words never arrived", decoded_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("trie_node_prefix_parser_core test passed");
        end else begin
            $display("trie_node_prefix_parser_core test failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/tnpp_pkg.sv
rtl/tnpp_step.sv
rtl/tnpp_rq.sv
rtl/trie_node_prefix_parser_core.sv
rtl/tnpp_checker.sv
bench/trie_node_prefix_parser_core_test.sv
